/* sv/pmi_pkg.sv */
package pmi_pkg;

  localparam int unsigned MAX_FOLDS_DEF = 16;

  // register indexes on the configuration port
  localparam logic [2:0] REG_LENGTH_X = 3'd0;
  localparam logic [2:0] REG_LENGTH_Y = 3'd1;
  localparam logic [2:0] REG_LENGTH_Z = 3'd2;
  localparam logic [2:0] REG_TILT_XY  = 3'd3;
  localparam logic [2:0] REG_TILT_XZ  = 3'd4;
  localparam logic [2:0] REG_TILT_YZ  = 3'd5;
  localparam logic [2:0] REG_PERIODIC = 3'd6;
  localparam logic [2:0] REG_BOX_MODE = 3'd7;

  typedef logic [2:0] pc_t;

  // program entry points
  localparam pc_t PC_TRI   = 3'd0;
  localparam pc_t PC_ORTHO = 3'd4;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  typedef enum logic {
    OP_FOLD,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t   op;
    axis_t axis;
    logic  coupled;
    pc_t   nxt;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    logic  run;
    axis_t axis;
    logic  coupled;
    logic  fold;
    logic  cap_hit;
    logic  emit;
  } pmi_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic axis_en;
    logic out_of_range;
  } pmi_stat_t;

  // control store: triclinic program z, y, x; orthogonal program x, y, z
  function automatic ucode_t ucode(input pc_t pc);
    ucode_t w;
    case (pc)
      3'd0: w = '{op: OP_FOLD, axis: AX_Z, coupled: 1'b1, nxt: 3'd1};
      3'd1: w = '{op: OP_FOLD, axis: AX_Y, coupled: 1'b1, nxt: 3'd2};
      3'd2: w = '{op: OP_FOLD, axis: AX_X, coupled: 1'b0, nxt: 3'd3};
      3'd4: w = '{op: OP_FOLD, axis: AX_X, coupled: 1'b0, nxt: 3'd5};
      3'd5: w = '{op: OP_FOLD, axis: AX_Y, coupled: 1'b0, nxt: 3'd6};
      3'd6: w = '{op: OP_FOLD, axis: AX_Z, coupled: 1'b0, nxt: 3'd7};
      default: w = '{op: OP_EMIT, axis: AX_X, coupled: 1'b0, nxt: pc};
    endcase
    return w;
  endfunction

endpackage

/* sv/periodic_minimum_image_unit.sv */
// Minimum-image folding of one Q16.16 displacement vector. Raise start while busy is low to
// hand in an item; busy stays high until the result has gone out. Each periodic axis is
// checked and folded by one add per cycle under a small microprogram, with at most
// MAX_FOLDS folds per axis. out_valid is high for exactly one cycle and the receiver
// cannot stall it: the result must be captured in that cycle. Box registers must only be
// written while busy is low.
module periodic_minimum_image_unit #(
  parameter int unsigned MAX_FOLDS = pmi_pkg::MAX_FOLDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_delta_x,
  input  logic signed [31:0] in_delta_y,
  input  logic signed [31:0] in_delta_z,
  input  logic               in_batch_end,
  output logic               out_valid,
  output logic signed [31:0] out_folded_x,
  output logic signed [31:0] out_folded_y,
  output logic signed [31:0] out_folded_z,
  output logic               out_fold_limit_hit,
  output logic               out_batch_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
  localparam logic signed [33:0] SAT_LO = -34'sd2147483648;

  function automatic logic signed [31:0] tilt_step(input logic signed [31:0] b,
                                                   input logic signed [31:0] t,
                                                   input logic up);
    logic signed [33:0] s;
    s = up ? (34'(b) + 34'(t)) : (34'(b) - 34'(t));
    if (s > SAT_HI) begin
      return SAT_HI[31:0];
    end else if (s < SAT_LO) begin
      return SAT_LO[31:0];
    end
    return s[31:0];
  endfunction

  logic [30:0]        cfg_length_x_r, cfg_length_y_r, cfg_length_z_r;
  logic signed [31:0] cfg_tilt_xy_r, cfg_tilt_xz_r, cfg_tilt_yz_r;
  logic [2:0]         cfg_periodic_r;
  logic [1:0]         cfg_box_mode_r;
  logic               cfg_wr;

  logic signed [31:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic               hit_r, hit_nxt;
  logic               last_r;
  logic               go;

  pmi_pkg::pmi_ctrl_t ctrl;
  pmi_pkg::pmi_stat_t stat;

  logic signed [31:0] a;
  logic [30:0]        len;
  logic signed [32:0] a_ext, len_ext, a_fold;
  logic [32:0]        mag, two_mag;
  logic               neg;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_length_x_r <= 31'd65536;
      cfg_length_y_r <= 31'd65536;
      cfg_length_z_r <= 31'd65536;
      cfg_tilt_xy_r  <= '0;
      cfg_tilt_xz_r  <= '0;
      cfg_tilt_yz_r  <= '0;
      cfg_periodic_r <= 3'b111;
      cfg_box_mode_r <= 2'b10;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        pmi_pkg::REG_LENGTH_X: cfg_length_x_r <= pwdata[30:0];
        pmi_pkg::REG_LENGTH_Y: cfg_length_y_r <= pwdata[30:0];
        pmi_pkg::REG_LENGTH_Z: cfg_length_z_r <= pwdata[30:0];
        pmi_pkg::REG_TILT_XY:  cfg_tilt_xy_r  <= pwdata;
        pmi_pkg::REG_TILT_XZ:  cfg_tilt_xz_r  <= pwdata;
        pmi_pkg::REG_TILT_YZ:  cfg_tilt_yz_r  <= pwdata;
        pmi_pkg::REG_PERIODIC: cfg_periodic_r <= pwdata[2:0];
        pmi_pkg::REG_BOX_MODE: cfg_box_mode_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      pmi_pkg::REG_LENGTH_X: prdata = {1'b0, cfg_length_x_r};
      pmi_pkg::REG_LENGTH_Y: prdata = {1'b0, cfg_length_y_r};
      pmi_pkg::REG_LENGTH_Z: prdata = {1'b0, cfg_length_z_r};
      pmi_pkg::REG_TILT_XY:  prdata = cfg_tilt_xy_r;
      pmi_pkg::REG_TILT_XZ:  prdata = cfg_tilt_xz_r;
      pmi_pkg::REG_TILT_YZ:  prdata = cfg_tilt_yz_r;
      pmi_pkg::REG_PERIODIC: prdata = {29'd0, cfg_periodic_r};
      pmi_pkg::REG_BOX_MODE: prdata = {30'd0, cfg_box_mode_r};
      default:               prdata = '0;
    endcase
  end

  // sequencer
  assign go   = start && !ctrl.run;
  assign busy = ctrl.run;

  pmi_seq #(
    .MAX_FOLDS (MAX_FOLDS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .tri_mode (cfg_box_mode_r[0]),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // fold datapath: one range test and one add per cycle on the selected axis
  always_comb begin
    case (ctrl.axis)
      pmi_pkg::AX_Y: begin
        a            = y_r;
        len          = cfg_length_y_r;
        stat.axis_en = cfg_periodic_r[1];
      end
      pmi_pkg::AX_Z: begin
        a            = z_r;
        len          = cfg_length_z_r;
        stat.axis_en = cfg_periodic_r[2] && cfg_box_mode_r[1];
      end
      default: begin
        a            = x_r;
        len          = cfg_length_x_r;
        stat.axis_en = cfg_periodic_r[0];
      end
    endcase

    neg     = a[31];
    a_ext   = 33'(a);
    len_ext = signed'({2'b00, len});
    mag     = neg ? unsigned'(-a_ext) : unsigned'(a_ext);
    two_mag = {mag[31:0], 1'b0};
    stat.out_of_range = (two_mag > {2'b00, len});
    // negative component moves up by one box length, otherwise down
    a_fold  = neg ? (a_ext + len_ext) : (a_ext - len_ext);
  end

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    z_nxt   = z_r;
    hit_nxt = hit_r;
    if (go) begin
      x_nxt   = in_delta_x;
      y_nxt   = in_delta_y;
      z_nxt   = in_delta_z;
      hit_nxt = 1'b0;
    end else begin
      if (ctrl.cap_hit) begin
        hit_nxt = 1'b1;
      end
      if (ctrl.fold) begin
        case (ctrl.axis)
          pmi_pkg::AX_Z: begin
            z_nxt = a_fold[31:0];
            if (ctrl.coupled) begin
              y_nxt = tilt_step(y_r, cfg_tilt_yz_r, neg);
              x_nxt = tilt_step(x_r, cfg_tilt_xz_r, neg);
            end
          end
          pmi_pkg::AX_Y: begin
            y_nxt = a_fold[31:0];
            if (ctrl.coupled) begin
              x_nxt = tilt_step(x_r, cfg_tilt_xy_r, neg);
            end
          end
          default: begin
            x_nxt = a_fold[31:0];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    hit_r <= hit_nxt;
    if (go) begin
      last_r <= in_batch_end;
    end
  end

  assign out_valid          = ctrl.emit;
  assign out_folded_x       = x_r;
  assign out_folded_y       = y_r;
  assign out_folded_z       = z_r;
  assign out_fold_limit_hit = hit_r;
  assign out_batch_last     = last_r;

endmodule

/* sv/pmi_seq.sv */
module pmi_seq #(
  parameter int unsigned MAX_FOLDS = pmi_pkg::MAX_FOLDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic                tri_mode,
  input  pmi_pkg::pmi_stat_t  stat,
  output pmi_pkg::pmi_ctrl_t  ctrl
);

  localparam int unsigned CNT_W = $clog2(MAX_FOLDS + 1);

  logic             run_r, run_nxt;
  pmi_pkg::pc_t     pc_r, pc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  pmi_pkg::ucode_t  word;
  logic             act;
  logic             at_cap;

  always_comb begin
    word   = pmi_pkg::ucode(pc_r);
    at_cap = (cnt_r == CNT_W'(MAX_FOLDS));
    act    = run_r && (word.op == pmi_pkg::OP_FOLD) && stat.axis_en && stat.out_of_range;

    ctrl.run     = run_r;
    ctrl.axis    = word.axis;
    ctrl.coupled = word.coupled;
    ctrl.fold    = act && !at_cap;
    ctrl.cap_hit = act && at_cap;
    ctrl.emit    = run_r && (word.op == pmi_pkg::OP_EMIT);

    run_nxt = run_r;
    pc_nxt  = pc_r;
    cnt_nxt = cnt_r;
    if (go) begin
      run_nxt = 1'b1;
      pc_nxt  = tri_mode ? pmi_pkg::PC_TRI : pmi_pkg::PC_ORTHO;
      cnt_nxt = '0;
    end else if (run_r) begin
      if (ctrl.emit) begin
        run_nxt = 1'b0;
      end else if (ctrl.fold) begin
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        // axis in range, capped or not periodic: next step
        pc_nxt  = word.nxt;
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      pc_r  <= '0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
